### hdl/rlbe_pkg.sv
// Shared types and constants of the run-length byte encoder.
`default_nettype none
package rlbe_pkg;

  localparam int unsigned RUN_W = 8;
  localparam logic [7:0] RUN_FLAG = 8'h80;
  localparam logic [RUN_W-1:0] RUN_MIN = 8'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_CLOSE,
    S_ADD,
    S_RHDR,
    S_RVAL,
    S_CLOSED,
    S_HDR,
    S_ROW,
    S_FINISH
  } rlbe_state_t;

  // Which run close is in progress within one item.
  typedef enum logic [1:0] {
    PH_OLD,
    PH_FINAL,
    PH_TAIL
  } rlbe_phase_t;

  typedef struct packed {
    logic load;
    logic extend;
    logic start_run;
    logic add_lit;
    logic push_rhdr;
    logic push_rval;
    logic push_lhdr;
    logic push_row;
    logic finish;
  } rlbe_cmd_t;

  typedef struct packed {
    logic cont;
    logic run_ge3;
    logic run_nz;
    logic lit_nz;
    logic lit_fill;
    logic fin;
    logic fill_nz;
    logic out_free;
    logic row_last;
  } rlbe_status_t;

endpackage
`default_nettype wire

### hdl/run_length_byte_encoder_top.sv
// Top level of the run-length byte encoder: sequencer, datapath, stream ports and checks.
//
//   channel | dir | tdata                               | tuser      | tlast
//   s_*     | in  | [7:0] data_byte                     | -          | final_byte
//   m_*     | out | [63:0] packed_bytes, [67:64] count  | stream_end | run_last
//
// Items are taken one at a time. A byte that extends a run and is not final passes only the
// evaluation state; one that closes a short run moves its bytes into the literal buffer one by
// one; closing a run of three or more pushes a flag byte and a value byte, then hands off the
// last word. A literal flush pushes a header and then one row of OUT_LANES bytes at a time
// through the buffer's single read port. Reset is synchronous; the buffer is read only below its
// fill count, so it needs no clearing. A held output register stalls the sequencer at its next
// push or hand-off, and input is taken again once the item's last word sits in that register.
`default_nettype none
module run_length_byte_encoder_top #(
  parameter int unsigned LITERAL_MAX = 128,
  parameter int unsigned RUN_MAX     = 130,
  parameter int unsigned OUT_LANES   = 8
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] data_byte
  input  wire         s_tlast,   // final_byte
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [71:0] m_tdata,   // [63:0] packed_bytes, [67:64] byte_count, [71:68] zero
  output logic        m_tuser,   // stream_end
  output logic        m_tlast    // run_last
);
  import rlbe_pkg::*;

  rlbe_cmd_t    cmd;
  rlbe_status_t status;
  logic [63:0]  out_bytes;
  logic [3:0]   out_count;

  // The sequencer decides the order of byte pushes; the datapath does the work.
  rlbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rlbe_dp #(
    .LITERAL_MAX (LITERAL_MAX),
    .RUN_MAX     (RUN_MAX),
    .OUT_LANES   (OUT_LANES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (s_tdata),
    .in_final  (s_tlast),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_bytes (out_bytes),
    .out_count (out_count),
    .out_last  (m_tlast),
    .out_end   (m_tuser)
  );

  assign m_tdata = {4'b0000, out_count, out_bytes};

  // A result always carries between one and OUT_LANES bytes.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_count != 4'd0) && (out_count <= 4'(OUT_LANES)))
    else $error("result byte count out of range");

  // The end of the stream is always the last result of its item.
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("stream end without run last");

  // The sequencer never pushes bytes while a result waits in the output register.
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_rhdr || cmd.push_rval || cmd.push_lhdr || cmd.push_row || cmd.finish)
      |-> (status.out_free || !status.fill_nz))
    else $error("byte push while output register is held");

  // A new item is taken only after the previous item's bytes have all left the packer.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !status.fill_nz)
    else $error("item accepted with bytes still packed");

endmodule
`default_nettype wire

### hdl/rlbe_ctrl.sv
// Sequencer of the run-length byte encoder: walks each item through its run close and flushes.
`default_nettype none
module rlbe_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  input  rlbe_pkg::rlbe_status_t status,
  output rlbe_pkg::rlbe_cmd_t    cmd
);
  import rlbe_pkg::*;

  rlbe_state_t state, state_next;
  rlbe_phase_t phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_OLD;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          phase_next = PH_OLD;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status.cont) begin
          cmd.extend = 1'b1;
          if (status.fin) begin
            phase_next = PH_FINAL;
            state_next = S_CLOSE;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (status.run_ge3) begin
          state_next = status.lit_nz ? S_HDR : S_RHDR;
        end else if (status.run_nz) begin
          state_next = S_ADD;
        end else begin
          state_next = S_CLOSED;
        end
      end
      S_ADD: begin
        cmd.add_lit = 1'b1;
        state_next  = status.lit_fill ? S_HDR : S_CLOSE;
      end
      S_RHDR: begin
        if (status.out_free) begin
          cmd.push_rhdr = 1'b1;
          state_next    = S_RVAL;
        end
      end
      S_RVAL: begin
        if (status.out_free) begin
          cmd.push_rval = 1'b1;
          state_next    = S_CLOSED;
        end
      end
      S_CLOSED: begin
        case (phase)
          PH_OLD: begin
            cmd.start_run = 1'b1;
            if (status.fin) begin
              phase_next = PH_FINAL;
              state_next = S_CLOSE;
            end else begin
              state_next = status.fill_nz ? S_FINISH : S_IDLE;
            end
          end
          PH_FINAL: begin
            if (status.lit_nz) begin
              phase_next = PH_TAIL;
              state_next = S_HDR;
            end else begin
              state_next = S_FINISH;
            end
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_HDR: begin
        if (status.out_free) begin
          cmd.push_lhdr = 1'b1;
          state_next    = S_ROW;
        end
      end
      S_ROW: begin
        if (status.out_free) begin
          cmd.push_row = 1'b1;
          if (status.row_last) begin
            state_next = (phase == PH_TAIL) ? S_FINISH : S_CLOSE;
          end
        end
      end
      S_FINISH: begin
        if (status.out_free || !status.fill_nz) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### hdl/rlbe_dp.sv
// Datapath of the run-length byte encoder: run state, literal buffer, byte packer, output register.
`default_nettype none
module rlbe_dp #(
  parameter int unsigned LITERAL_MAX = 128,
  parameter int unsigned RUN_MAX     = 130,
  parameter int unsigned OUT_LANES   = 8
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire  [7:0]             in_byte,
  input  wire                    in_final,
  input  rlbe_pkg::rlbe_cmd_t    cmd,
  output rlbe_pkg::rlbe_status_t status,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [63:0]            out_bytes,
  output logic [3:0]             out_count,
  output logic                   out_last,
  output logic                   out_end
);
  import rlbe_pkg::*;

  localparam int unsigned LW     = OUT_LANES * 8;
  localparam int unsigned CNT_W  = $clog2(LITERAL_MAX + 1);
  localparam int unsigned ROWS   = (LITERAL_MAX + OUT_LANES - 1) / OUT_LANES;
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned LANE_W = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;
  localparam int unsigned FILL_W = $clog2(OUT_LANES + 1);
  localparam int unsigned TOT_W  = $clog2(2 * OUT_LANES + 1);
  localparam logic [RUN_W-1:0]  RUN_CAP   = RUN_W'(RUN_MAX);
  localparam logic [CNT_W-1:0]  LIT_LAST  = CNT_W'(LITERAL_MAX - 1);
  localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(OUT_LANES - 1);
  localparam logic [FILL_W-1:0] LANES_F   = FILL_W'(OUT_LANES);
  localparam logic [TOT_W-1:0]  LANES_T   = TOT_W'(OUT_LANES);

  // Item and run state.
  logic [7:0]       cur_byte;
  logic             cur_final;
  logic [7:0]       run_value;
  logic [RUN_W-1:0] run_length;

  // Literal buffer, one row per output word.
  logic [LW-1:0]     lit_mem [ROWS];
  logic [LW-1:0]     rd_data;
  logic [ROW_W-1:0]  rd_row;
  logic [ROW_W-1:0]  rd_addr;
  logic [ROW_W-1:0]  wr_row;
  logic [LANE_W-1:0] wr_lane;
  logic [CNT_W-1:0]  lit_count;
  logic [CNT_W-1:0]  flush_left;

  // Packer.
  logic [LW-1:0]     acc;
  logic [FILL_W-1:0] fill;
  logic [LW-1:0]     src;
  logic [LW-1:0]     src_m;
  logic [FILL_W-1:0] src_n;
  logic              push;
  logic [TOT_W-1:0]  total;
  logic [2*LW-1:0]   comb;
  logic              emit_full;
  logic              emit_fin;
  logic [LW-1:0]     out_word;

  assign rd_addr = cmd.push_row ? ROW_W'(rd_row + 1'b1) : rd_row;

  always_comb begin
    src   = '0;
    src_n = '0;
    if (cmd.push_rhdr) begin
      src   = LW'({1'b1, 7'(run_length - RUN_MIN)});
      src_n = FILL_W'(1);
    end else if (cmd.push_rval) begin
      src   = LW'(run_value);
      src_n = FILL_W'(1);
    end else if (cmd.push_lhdr) begin
      src   = LW'(8'(lit_count - 1'b1));
      src_n = FILL_W'(1);
    end else if (cmd.push_row) begin
      src   = rd_data;
      src_n = (flush_left >= OUT_LANES) ? LANES_F : FILL_W'(flush_left);
    end
  end

  // Lanes past the valid count may hold stale buffer bytes.
  always_comb begin
    for (int l = 0; l < OUT_LANES; l++) begin
      src_m[l*8 +: 8] = (l < src_n) ? src[l*8 +: 8] : 8'h00;
    end
  end

  assign push      = cmd.push_rhdr | cmd.push_rval | cmd.push_lhdr | cmd.push_row;
  assign total     = TOT_W'(fill) + TOT_W'(src_n);
  assign comb      = {{LW{1'b0}}, acc} | ({{LW{1'b0}}, src_m} << {fill, 3'b000});
  assign emit_full = push && (total > LANES_T);
  assign emit_fin  = cmd.finish && (fill != '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_byte  <= in_byte;
      cur_final <= in_final;
    end
    if (cmd.add_lit) begin
      lit_mem[wr_row][{wr_lane, 3'b000} +: 8] <= run_value;
    end
    rd_data <= lit_mem[rd_addr];
    if (emit_full) begin
      out_word  <= comb[LW-1:0];
      out_count <= 4'(OUT_LANES);
      out_last  <= 1'b0;
      out_end   <= 1'b0;
    end else if (emit_fin) begin
      out_word  <= acc;
      out_count <= 4'(fill);
      out_last  <= 1'b1;
      out_end   <= cur_final;
    end
    if (cmd.push_lhdr) begin
      flush_left <= lit_count;
    end else if (cmd.push_row) begin
      flush_left <= flush_left - CNT_W'(src_n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_value  <= '0;
      run_length <= '0;
      lit_count  <= '0;
      wr_row     <= '0;
      wr_lane    <= '0;
      rd_row     <= '0;
      acc        <= '0;
      fill       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.extend) begin
        run_length <= run_length + 1'b1;
      end else if (cmd.start_run) begin
        run_value  <= cur_byte;
        run_length <= RUN_W'(1);
      end else if (cmd.add_lit) begin
        run_length <= run_length - 1'b1;
      end else if (cmd.push_rval) begin
        run_length <= '0;
      end else if (cmd.finish && cur_final) begin
        run_value  <= '0;
        run_length <= '0;
      end

      if (cmd.add_lit) begin
        lit_count <= lit_count + 1'b1;
        if (wr_lane == LANE_LAST) begin
          wr_lane <= '0;
          wr_row  <= ROW_W'(wr_row + 1'b1);
        end else begin
          wr_lane <= LANE_W'(wr_lane + 1'b1);
        end
      end else if (cmd.push_row && status.row_last) begin
        lit_count <= '0;
        wr_lane   <= '0;
        wr_row    <= '0;
      end

      if (cmd.push_row) begin
        rd_row <= status.row_last ? '0 : ROW_W'(rd_row + 1'b1);
      end

      if (push) begin
        if (total > LANES_T) begin
          acc  <= comb[2*LW-1:LW];
          fill <= FILL_W'(total - LANES_T);
        end else begin
          acc  <= comb[LW-1:0];
          fill <= FILL_W'(total);
        end
      end else if (cmd.finish) begin
        acc  <= '0;
        fill <= '0;
      end

      if (emit_full || emit_fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_bytes = 64'(out_word);

  always_comb begin
    status.cont     = (run_length != '0) && (cur_byte == run_value) && (run_length < RUN_CAP);
    status.run_ge3  = run_length >= RUN_MIN;
    status.run_nz   = run_length != '0;
    status.lit_nz   = lit_count != '0;
    status.lit_fill = lit_count == LIT_LAST;
    status.fin      = cur_final;
    status.fill_nz  = fill != '0;
    status.out_free = !out_valid || out_ready;
    status.row_last = flush_left <= OUT_LANES;
  end

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench of the run-length byte encoder, driven through its stream ports.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIT_MAX      = 128;
  localparam int unsigned RUN_CAP      = 130;
  localparam int unsigned LANES        = 8;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES  = 300;

  // One compressed word as the master side hands it over.
  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        run_last;
    logic        stream_end;
  } enc_word_t;

  // One directed item. When typed is set, want is the single word that the item must produce.
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       typed;
    enc_word_t  want;
  } stim_row_t;

  localparam enc_word_t NO_WORD = '0;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [71:0] m_tdata;
  wire         m_tuser;
  wire         m_tlast;

  // Typed expectation that travels alongside the item currently offered.
  logic        s_typed = 1'b0;
  enc_word_t   s_want  = '0;

  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 74;
  int unsigned errors        = 0;
  int unsigned sent          = 0;
  int unsigned cycles        = 0;

  // A toggle of hold_req asks the receiver for one long stall.
  logic        hold_req  = 1'b0;
  logic        hold_ack  = 1'b0;
  int unsigned hold_left = 0;

  // Encoder state as the predictor sees it.
  logic [7:0]  run_val = 8'h00;
  int unsigned run_len = 0;
  logic [7:0]  lit_buf [LIT_MAX];
  int unsigned lit_cnt = 0;
  logic [7:0]  out_bytes [$];
  enc_word_t   expected_words [$];

  logic [7:0]  stream_q [$];
  stim_row_t   directed_rows [25];

  run_length_byte_encoder_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever begin
      #10 clk = ~clk;
    end
  end

  // Pending literals go out as a count-minus-one flag followed by the bytes.
  function automatic void flush_literals();
    if (lit_cnt != 0) begin
      out_bytes.push_back(8'(lit_cnt - 1));
      for (int i = 0; i < lit_cnt; i++) out_bytes.push_back(lit_buf[i]);
      lit_cnt = 0;
    end
  endfunction

  function automatic void add_literal(input logic [7:0] b);
    lit_buf[lit_cnt] = b;
    lit_cnt++;
    if (lit_cnt == LIT_MAX) flush_literals();
  endfunction

  // A run of three or more becomes a flag and a value; a shorter one joins the literals.
  function automatic void close_run();
    if (run_len >= rlbe_pkg::RUN_MIN) begin
      flush_literals();
      out_bytes.push_back(rlbe_pkg::RUN_FLAG | 8'(run_len - 3));
      out_bytes.push_back(run_val);
    end else begin
      for (int i = 0; i < run_len; i++) add_literal(run_val);
    end
    run_len = 0;
  endfunction

  // Encodes one input byte and queues the words that it should produce.
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    enc_word_t   w;
    int unsigned n;
    out_bytes.delete();
    if (run_len > 0 && b == run_val && run_len < RUN_CAP) begin
      run_len++;
    end else begin
      close_run();
      run_val = b;
      run_len = 1;
    end
    if (fin) begin
      close_run();
      flush_literals();
      run_val = 8'h00;
      run_len = 0;
    end
    while (out_bytes.size() > 0) begin
      w = '0;
      n = (out_bytes.size() > LANES) ? LANES : out_bytes.size();
      for (int k = 0; k < n; k++) w.bytes[8*k +: 8] = out_bytes.pop_front();
      w.count      = 4'(n);
      w.run_last   = (out_bytes.size() == 0);
      w.stream_end = w.run_last && fin;
      expected_words.push_back(w);
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    errors++;
  endtask

  task automatic check_word(input enc_word_t got, input enc_word_t want);
    if (got.bytes !== want.bytes)
      report_mismatch($sformatf("packed_bytes %h, expected %h", got.bytes, want.bytes));
    if (got.count !== want.count)
      report_mismatch($sformatf("byte_count %0d, expected %0d", got.count, want.count));
    if (got.run_last !== want.run_last)
      report_mismatch($sformatf("run_last %b, expected %b", got.run_last, want.run_last));
    if (got.stream_end !== want.stream_end)
      report_mismatch($sformatf("stream_end %b, expected %b", got.stream_end, want.stream_end));
  endtask

  // Both handshakes are sampled at the rising edge. The output side is checked first, so a
  // word that arrives with nothing expected is never matched against the item taken at the
  // same edge.
  always @(posedge clk) begin : watch_ports
    enc_word_t   got;
    int unsigned depth;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[63:0], m_tdata[67:64], m_tlast, m_tuser};
        if (expected_words.size() == 0) report_mismatch("result with nothing expected");
        else check_word(got, expected_words.pop_front());
      end
      if (s_tvalid && s_tready) begin
        depth = expected_words.size();
        encode_byte(s_tdata, s_tlast);
        // A typed row replaces what the predictor worked out for that item.
        if (s_typed) begin
          while (expected_words.size() > depth) void'(expected_words.pop_back());
          expected_words.push_back(s_want);
        end
      end
    end
  end

  // Receiver: random stalls, or one long stall when asked, counted here.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offers one item after a random gap and returns at the edge that takes it. Valid stays
  // high when the next item follows without a gap.
  task automatic send_item(input logic [7:0] data, input logic fin, input logic typed,
                           input enc_word_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tlast  <= fin;
    s_typed  <= typed;
    s_want   <= want;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // Bytes from a small set make accidental runs across segment borders likely.
  function automatic logic [7:0] pick_byte();
    logic [7:0] corners [4] = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    if ($urandom_range(1) == 0) return corners[$urandom_range(3)];
    return 8'($urandom);
  endfunction

  task automatic add_run(input logic [7:0] v, input int unsigned len);
    repeat (len) stream_q.push_back(v);
  endtask

  // Each byte differs from the one before, so none of them starts a run.
  task automatic add_literals(input int unsigned len);
    logic [7:0] v;
    repeat (len) begin
      do v = 8'($urandom); while (stream_q.size() != 0 && v == stream_q[$]);
      stream_q.push_back(v);
    end
  endtask

  // Sends the built stream with the final flag on its last byte.
  task automatic send_stream();
    foreach (stream_q[i]) send_item(stream_q[i], i == stream_q.size() - 1, 1'b0, NO_WORD);
    stream_q.delete();
  endtask

  task automatic send_random_stream();
    int unsigned segs;
    segs = $urandom_range(1, 6);
    repeat (segs) begin
      case ($urandom_range(9))
        0, 1, 2, 3: add_run(pick_byte(), $urandom_range(1, 2));
        4, 5, 6:    add_run(pick_byte(), $urandom_range(3, 12));
        7, 8:       add_literals($urandom_range(1, 12));
        default:    add_run(pick_byte(), $urandom_range(20, 40));
      endcase
    end
    send_stream();
  endtask

  task automatic random_phase(input int unsigned n_items);
    int unsigned first;
    first = sent;
    while (sent - first < n_items) send_random_stream();
  endtask

  initial begin
    // Every directed stream closes with its final byte, so each row group starts clean.
    directed_rows = '{
      // Lone final byte right after reset: one literal.
      {8'hA5, 1'b1, 1'b1, 64'h0000_0000_0000_A500, 4'd2, 1'b1, 1'b1},
      // Shortest run, of zeros, closed by the final byte.
      {8'h00, 1'b0, 1'b0, NO_WORD},
      {8'h00, 1'b0, 1'b0, NO_WORD},
      {8'h00, 1'b1, 1'b1, 64'h0000_0000_0000_0080, 4'd2, 1'b1, 1'b1},
      // A pair of 0xFF falls back to literals.
      {8'hFF, 1'b0, 1'b0, NO_WORD},
      {8'hFF, 1'b0, 1'b0, NO_WORD},
      {8'h01, 1'b1, 1'b1, 64'h0000_0000_01FF_FF02, 4'd4, 1'b1, 1'b1},
      // Run of four closed by a different final byte.
      {8'h3C, 1'b0, 1'b0, NO_WORD},
      {8'h3C, 1'b0, 1'b0, NO_WORD},
      {8'h3C, 1'b0, 1'b0, NO_WORD},
      {8'h3C, 1'b0, 1'b0, NO_WORD},
      {8'h3D, 1'b1, 1'b0, NO_WORD},
      // A literal pending when a run closes is flushed ahead of the run.
      {8'h11, 1'b0, 1'b0, NO_WORD},
      {8'h22, 1'b0, 1'b0, NO_WORD},
      {8'h22, 1'b0, 1'b0, NO_WORD},
      {8'h22, 1'b0, 1'b0, NO_WORD},
      {8'h33, 1'b1, 1'b0, NO_WORD},
      // Eight literals: nine bytes spill into a second word.
      {8'h01, 1'b0, 1'b0, NO_WORD},
      {8'h02, 1'b0, 1'b0, NO_WORD},
      {8'h03, 1'b0, 1'b0, NO_WORD},
      {8'h04, 1'b0, 1'b0, NO_WORD},
      {8'h05, 1'b0, 1'b0, NO_WORD},
      {8'h06, 1'b0, 1'b0, NO_WORD},
      {8'h07, 1'b0, 1'b0, NO_WORD},
      {8'h08, 1'b1, 1'b0, NO_WORD}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].data, directed_rows[i].fin, directed_rows[i].typed,
                directed_rows[i].want);

    // Sender idles less than the receiver.
    random_phase(10);
    // A run past its cap closes at the cap and the rest starts a new run.
    add_literals(3);
    add_run(pick_byte(), $urandom_range(131, 134));
    send_stream();

    // Receiver idles less than the sender.
    send_idle_pct = 74;
    recv_idle_pct = 31;
    random_phase(10);
    // Enough literals to fill the store and force a flush of seventeen words.
    add_literals($urandom_range(129, 132));
    send_stream();

    // No idling at all; the receiver first holds off while items keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= ~hold_req;
    random_phase(10);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
hdl/rlbe_pkg.sv
hdl/rlbe_ctrl.sv
hdl/rlbe_dp.sv
hdl/run_length_byte_encoder_top.sv
tb/tb.sv
